[rtl/awac_pkg.sv]
// Package for the aero wing angle controller: constants, mode codes,
// the sine table and the steering ratio bands.
// Used by every file of the block; depends on nothing.
package awac_pkg;

  localparam int unsigned DIV_W = 17;   // dividend, divisor and quotient width
  localparam int unsigned MUL_AW = 52;  // multiplicand and product width
  localparam int unsigned MUL_BW = 19;  // multiplier width

  localparam logic [2:0] MODE_DOWNFORCE = 3'd0;
  localparam logic [2:0] MODE_WIDE      = 3'd1;
  localparam logic [2:0] MODE_BRAKE     = 3'd2;
  localparam logic [2:0] MODE_THROTTLE  = 3'd3;
  localparam logic [2:0] MODE_TRIM      = 3'd4;

  localparam logic [2:0] REG_CLOSE_RH = 3'd0;

  localparam logic [16:0] LENGTH_Q16    = 17'd105513;
  localparam logic [14:0] STRAIGHT_RAD  = 15'd32767;
  localparam logic [14:0] WIDE_RAD      = 15'd50;
  localparam logic [7:0]  PEDAL_TRIP    = 8'd178;
  localparam logic [8:0]  CAR_KG        = 9'd230;
  localparam logic [9:0]  G_HUNDREDTHS  = 10'd981;
  localparam logic [6:0]  PCT           = 7'd100;

  // sin(k degrees) in Q1.16, k = 0..90
  function automatic logic [16:0] sin_q(input logic [6:0] k);
    logic [16:0] v;
    begin
      case (k)
        7'd0: v = 17'd0;         7'd1: v = 17'd1144;      7'd2: v = 17'd2287;
        7'd3: v = 17'd3430;      7'd4: v = 17'd4572;      7'd5: v = 17'd5712;
        7'd6: v = 17'd6850;      7'd7: v = 17'd7987;      7'd8: v = 17'd9121;
        7'd9: v = 17'd10252;     7'd10: v = 17'd11380;    7'd11: v = 17'd12505;
        7'd12: v = 17'd13626;    7'd13: v = 17'd14742;    7'd14: v = 17'd15855;
        7'd15: v = 17'd16962;    7'd16: v = 17'd18064;    7'd17: v = 17'd19161;
        7'd18: v = 17'd20252;    7'd19: v = 17'd21336;    7'd20: v = 17'd22415;
        7'd21: v = 17'd23486;    7'd22: v = 17'd24550;    7'd23: v = 17'd25607;
        7'd24: v = 17'd26656;    7'd25: v = 17'd27697;    7'd26: v = 17'd28729;
        7'd27: v = 17'd29753;    7'd28: v = 17'd30767;    7'd29: v = 17'd31772;
        7'd30: v = 17'd32768;    7'd31: v = 17'd33754;    7'd32: v = 17'd34729;
        7'd33: v = 17'd35693;    7'd34: v = 17'd36647;    7'd35: v = 17'd37590;
        7'd36: v = 17'd38521;    7'd37: v = 17'd39441;    7'd38: v = 17'd40348;
        7'd39: v = 17'd41243;    7'd40: v = 17'd42126;    7'd41: v = 17'd42995;
        7'd42: v = 17'd43852;    7'd43: v = 17'd44695;    7'd44: v = 17'd45525;
        7'd45: v = 17'd46341;    7'd46: v = 17'd47143;    7'd47: v = 17'd47930;
        7'd48: v = 17'd48703;    7'd49: v = 17'd49461;    7'd50: v = 17'd50203;
        7'd51: v = 17'd50931;    7'd52: v = 17'd51643;    7'd53: v = 17'd52339;
        7'd54: v = 17'd53020;    7'd55: v = 17'd53684;    7'd56: v = 17'd54332;
        7'd57: v = 17'd54963;    7'd58: v = 17'd55578;    7'd59: v = 17'd56175;
        7'd60: v = 17'd56756;    7'd61: v = 17'd57319;    7'd62: v = 17'd57865;
        7'd63: v = 17'd58393;    7'd64: v = 17'd58903;    7'd65: v = 17'd59396;
        7'd66: v = 17'd59870;    7'd67: v = 17'd60326;    7'd68: v = 17'd60764;
        7'd69: v = 17'd61183;    7'd70: v = 17'd61584;    7'd71: v = 17'd61966;
        7'd72: v = 17'd62328;    7'd73: v = 17'd62672;    7'd74: v = 17'd62997;
        7'd75: v = 17'd63303;    7'd76: v = 17'd63589;    7'd77: v = 17'd63856;
        7'd78: v = 17'd64104;    7'd79: v = 17'd64332;    7'd80: v = 17'd64540;
        7'd81: v = 17'd64729;    7'd82: v = 17'd64898;    7'd83: v = 17'd65048;
        7'd84: v = 17'd65177;    7'd85: v = 17'd65287;    7'd86: v = 17'd65376;
        7'd87: v = 17'd65446;    7'd88: v = 17'd65496;    7'd89: v = 17'd65526;
        7'd90: v = 17'd65536;
        default: v = 17'd65536;
      endcase
      return v;
    end
  endfunction

  // steering ratio in hundredths for an absolute steering angle
  function automatic logic [8:0] ratio_hd(input logic [7:0] a);
    logic [8:0] r;
    begin
      if (a <= 8'd7) r = 9'd400;
      else if (a <= 8'd19) r = 9'd399;
      else if (a <= 8'd30) r = 9'd398;
      else if (a <= 8'd38) r = 9'd396;
      else if (a <= 8'd45) r = 9'd395;
      else if (a <= 8'd57) r = 9'd392;
      else if (a <= 8'd68) r = 9'd387;
      else if (a <= 8'd76) r = 9'd384;
      else if (a <= 8'd87) r = 9'd377;
      else if (a <= 8'd95) r = 9'd371;
      else if (a <= 8'd103) r = 9'd364;
      else if (a <= 8'd109) r = 9'd353;
      else r = 9'd338;
      return r;
    end
  endfunction

endpackage

[rtl/aero_wing_angle_controller_unit.sv]
// Aero wing angle controller, top level: APB registers, sequencer, wing state.
// Depends on awac_pkg, awac_serial_div and awac_serial_mul.
// The sequencer runs up to three divisions and seven bit-serial multiplications
//   in turn for each item; one item is in flight at a time.
// Reset: asynchronous, active low; wings return to zero, limits to defaults.
module aero_wing_angle_controller_unit #(
  parameter int unsigned ANGLE_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] pitch_rate_i,
  input  logic [7:0]         brake_level_i,
  input  logic [7:0]         throttle_level_i,
  input  logic [7:0]         steering_raw_i,
  input  logic [7:0]         grip_raw_i,
  input  logic [7:0]         driver_kg_i,
  input  logic signed [7:0]  roll_deg_i,
  input  logic [7:0]         speed_raw_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         angle_rear_high_o,
  output logic [7:0]         angle_rear_low_o,
  output logic [7:0]         angle_front_right_o,
  output logic [7:0]         angle_front_left_o,
  output logic [2:0]         wing_mode_o,
  output logic signed [15:0] corner_radius_o
);
  localparam int unsigned DW = awac_pkg::DIV_W;
  localparam int unsigned AW = awac_pkg::MUL_AW;
  localparam int unsigned BW = awac_pkg::MUL_BW;
  // wide enough for a wing angle or a limit plus one step either way
  localparam int unsigned CW = ((ANGLE_BITS > 8) ? ANGLE_BITS : 8) + 2;
  localparam logic REG_CLOSE_RH_BIT = awac_pkg::REG_CLOSE_RH[0];

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_S, ST_DIV_DEG, ST_DIV_RAD,
    ST_MUL_SQ, ST_MUL_T1, ST_MUL_NUM, ST_MUL_LHS,
    ST_MUL_DEN, ST_MUL_M981, ST_MUL_RHS, ST_OUT
  } state_e;

  state_e state_q;
  logic   start_q;

  // configuration registers: close limit (upper clamp) and open limit per wing
  logic [7:0] close_lim_q [4];
  logic [7:0] open_lim_q  [4];
  logic [2:0] reg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    if (reg_idx[0] == REG_CLOSE_RH_BIT) prdata = {24'd0, close_lim_q[reg_idx[2:1]]};
    else                                 prdata = {24'd0, open_lim_q[reg_idx[2:1]]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      close_lim_q[0] <= 8'd100;
      close_lim_q[1] <= 8'd100;
      close_lim_q[2] <= 8'd50;
      close_lim_q[3] <= 8'd50;
      for (int i = 0; i < 4; i++) open_lim_q[i] <= 8'd0;
    end else if (cfg_wr) begin
      // even index: close limit, odd index: open limit
      if (reg_idx[0] == REG_CLOSE_RH_BIT) close_lim_q[reg_idx[2:1]] <= pwdata[7:0];
      else                                 open_lim_q[reg_idx[2:1]]  <= pwdata[7:0];
    end
  end

  // captured item
  logic signed [15:0] pitch_q;
  logic [7:0]         brake_q, thr_q, steer_q, grip_q, kg_q, speed_q;
  logic signed [7:0]  roll_q;

  // intermediate results
  logic [7:0]  a_q;       // |steering angle| in degrees
  logic [6:0]  deg_q;     // wheel angle in degrees
  logic [14:0] rmag_q;    // |corner radius|
  logic [15:0] sq_q;
  logic [24:0] t1_q;
  logic [40:0] num_q;
  logic [47:0] lhs_q;
  logic [33:0] den_q;
  logic [18:0] m981_q;

  // shared arithmetic units
  logic          div_done, mul_done;
  logic [DW-1:0] div_dvd, div_dvs, div_quot;
  logic [AW-1:0] mul_a, mul_prod;
  logic [BW-1:0] mul_b;
  logic          div_start, mul_start;

  // steering: s = trunc((steer*141 - 18000) / 100)
  logic [15:0]        steer_mul;
  logic signed [16:0] steer_x;
  logic               s_neg;
  logic [14:0]        steer_mag;
  logic [8:0]         ratio;
  logic [16:0]        deg_dvd;
  logic [6:0]         deg_c;

  assign steer_mul = 16'(steer_q) * 16'd141;
  assign steer_x   = $signed({1'b0, steer_mul}) - 17'sd18000;
  assign s_neg     = steer_x[16];
  assign steer_mag = s_neg ? 15'(-steer_x) : steer_x[14:0];
  assign ratio     = awac_pkg::ratio_hd(a_q);
  assign deg_dvd   = 17'(a_q) * 17'd200 + 17'(ratio);
  assign deg_c     = (div_quot > 17'd90) ? 7'd90 : div_quot[6:0];

  // roll: clamp, then sine and cosine from the table
  logic signed [7:0]  roll_c;
  logic [6:0]         roll_abs;
  logic [16:0]        sin_abs, cosr;
  logic signed [18:0] sinr;
  logic [17:0]        fric;
  logic [9:0]         grip2;
  logic signed [18:0] diff;
  logic [17:0]        diff_mag;
  logic               r_neg;
  logic [8:0]         mass;

  always_comb begin
    if (roll_q > 8'sd90)       roll_c = 8'sd90;
    else if (roll_q < -8'sd90) roll_c = -8'sd90;
    else                       roll_c = roll_q;
  end

  assign roll_abs = roll_c[7] ? 7'(-roll_c) : roll_c[6:0];
  assign sin_abs  = awac_pkg::sin_q(roll_abs);
  assign cosr     = awac_pkg::sin_q(7'd90 - roll_abs);
  assign sinr     = roll_c[7] ? -$signed({2'b00, sin_abs}) : $signed({2'b00, sin_abs});
  // round(grip*2/255) in Q2.16 = grip*514 + rounding remainder
  assign grip2    = {1'b0, grip_q, 1'b0} + 10'd127;
  assign fric     = 18'(grip_q) * 18'd514
                  + ((grip2 >= 10'd510) ? 18'd2 : ((grip2 >= 10'd255) ? 18'd1 : 18'd0));
  assign diff     = $signed({1'b0, fric}) - sinr;
  assign diff_mag = diff[18] ? 18'(-diff) : diff[17:0];
  assign r_neg    = s_neg && (deg_q != 7'd0);
  assign mass     = awac_pkg::CAR_KG + 9'(kg_q);

  always_comb begin
    div_dvd = '0;
    div_dvs = '0;
    case (state_q)
      ST_DIV_S: begin
        div_dvd = DW'(steer_mag);
        div_dvs = DW'(awac_pkg::PCT);
      end
      ST_DIV_DEG: begin
        div_dvd = deg_dvd;
        div_dvs = DW'({ratio, 1'b0});
      end
      ST_DIV_RAD: begin
        div_dvd = awac_pkg::LENGTH_Q16;
        div_dvs = awac_pkg::sin_q(deg_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MUL_SQ:   begin mul_a = AW'(speed_q);   mul_b = BW'(speed_q);  end
      ST_MUL_T1:   begin mul_a = AW'(sq_q);      mul_b = BW'(mass);     end
      ST_MUL_NUM:  begin mul_a = AW'(t1_q);      mul_b = BW'(cosr);     end
      ST_MUL_LHS:  begin mul_a = AW'(num_q);     mul_b = BW'(awac_pkg::PCT); end
      ST_MUL_DEN:  begin mul_a = AW'(diff_mag);  mul_b = BW'(rmag_q);   end
      ST_MUL_M981: begin mul_a = AW'(awac_pkg::G_HUNDREDTHS); mul_b = BW'(mass); end
      ST_MUL_RHS:  begin mul_a = AW'(den_q);     mul_b = m981_q;        end
      default: ;
    endcase
  end

  assign div_start = start_q && (state_q == ST_DIV_S || state_q == ST_DIV_DEG ||
                                 state_q == ST_DIV_RAD);
  assign mul_start = start_q && !(state_q == ST_DIV_S || state_q == ST_DIV_DEG ||
                                  state_q == ST_DIV_RAD || state_q == ST_IDLE ||
                                  state_q == ST_OUT);

  awac_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  awac_serial_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // downforce test, settled when the last product lands
  logic den_pos, active_c;
  assign den_pos  = (diff != 19'sd0) && (r_neg == diff[18]);
  assign active_c = (diff == 19'sd0) ? (num_q != '0)
                                     : (den_pos && ({4'd0, lhs_q} > mul_prod));
  logic active_q;

  // mode selection and new wing angles
  logic [ANGLE_BITS-1:0] wing_q [4];
  logic [ANGLE_BITS-1:0] wing_d [4];
  logic [2:0]            mode_c;
  logic signed [CW-1:0]  w_tmp;
  logic signed [CW-1:0]  step;

  always_comb begin
    if (active_q)                          mode_c = awac_pkg::MODE_DOWNFORCE;
    else if (rmag_q > awac_pkg::WIDE_RAD)  mode_c = awac_pkg::MODE_WIDE;
    else if (brake_q > awac_pkg::PEDAL_TRIP) mode_c = awac_pkg::MODE_BRAKE;
    else if (thr_q > awac_pkg::PEDAL_TRIP)   mode_c = awac_pkg::MODE_THROTTLE;
    else                                   mode_c = awac_pkg::MODE_TRIM;
  end

  always_comb begin
    w_tmp = '0;
    step  = '0;
    for (int i = 0; i < 4; i++) begin
      wing_d[i] = wing_q[i];
      case (mode_c)
        awac_pkg::MODE_DOWNFORCE, awac_pkg::MODE_BRAKE: begin
          w_tmp     = $signed(CW'(close_lim_q[i]));
          wing_d[i] = w_tmp[ANGLE_BITS-1:0];
        end
        awac_pkg::MODE_WIDE, awac_pkg::MODE_THROTTLE: begin
          w_tmp     = $signed(CW'(open_lim_q[i]));
          wing_d[i] = w_tmp[ANGLE_BITS-1:0];
        end
        default: begin
          // rear wings follow the pitch sign, front wings go the other way
          if (pitch_q == 16'sd0)   step = '0;
          else if (pitch_q[15])    step = (i < 2) ? -CW'(1) : CW'(1);
          else                     step = (i < 2) ? CW'(1) : -CW'(1);
          w_tmp = $signed(CW'(wing_q[i])) + step;
          if (w_tmp > $signed(CW'(close_lim_q[i]))) w_tmp = $signed(CW'(close_lim_q[i]));
          if (w_tmp < $signed(CW'(open_lim_q[i])))  w_tmp = $signed(CW'(open_lim_q[i]));
          wing_d[i] = w_tmp[ANGLE_BITS-1:0];
        end
      endcase
    end
  end

  // sequencer
  logic              out_valid_q;
  logic [2:0]        mode_q;
  logic signed [15:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= awac_pkg::MODE_DOWNFORCE;
      radius_q    <= '0;
      active_q    <= 1'b0;
      for (int i = 0; i < 4; i++) wing_q[i] <= '0;
      pitch_q <= '0; brake_q <= '0; thr_q <= '0; steer_q <= '0;
      grip_q  <= '0; kg_q    <= '0; roll_q <= '0; speed_q <= '0;
      a_q <= '0; deg_q <= '0; rmag_q <= '0; sq_q <= '0; t1_q <= '0;
      num_q <= '0; lhs_q <= '0; den_q <= '0; m981_q <= '0;
    end else begin
      // launch the first unit when an item arrives, and the next whenever a step finishes, except after the last
      start_q <= (state_q == ST_IDLE && in_valid_i) || div_done ||
                 (mul_done && state_q != ST_MUL_RHS);
      if (out_ready_i && state_q != ST_OUT) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            pitch_q <= pitch_rate_i;    brake_q <= brake_level_i;
            thr_q   <= throttle_level_i; steer_q <= steering_raw_i;
            grip_q  <= grip_raw_i;      kg_q    <= driver_kg_i;
            roll_q  <= roll_deg_i;      speed_q <= speed_raw_i;
            state_q <= ST_DIV_S;
          end
        end
        ST_DIV_S: begin
          if (div_done) begin
            a_q     <= div_quot[7:0];
            state_q <= ST_DIV_DEG;
          end
        end
        ST_DIV_DEG: begin
          if (div_done) begin
            deg_q   <= deg_c;
            // a wheel angle of zero means driving straight
            if (deg_c == 7'd0) begin
              rmag_q  <= awac_pkg::STRAIGHT_RAD;
              state_q <= ST_MUL_SQ;
            end else begin
              state_q <= ST_DIV_RAD;
            end
          end
        end
        ST_DIV_RAD: begin
          if (div_done) begin
            rmag_q  <= div_quot[14:0];
            state_q <= ST_MUL_SQ;
          end
        end
        ST_MUL_SQ: begin
          if (mul_done) begin
            sq_q <= mul_prod[15:0]; state_q <= ST_MUL_T1;
          end
        end
        ST_MUL_T1: begin
          if (mul_done) begin
            t1_q <= mul_prod[24:0]; state_q <= ST_MUL_NUM;
          end
        end
        ST_MUL_NUM: begin
          if (mul_done) begin
            num_q <= mul_prod[40:0]; state_q <= ST_MUL_LHS;
          end
        end
        ST_MUL_LHS: begin
          if (mul_done) begin
            lhs_q <= mul_prod[47:0]; state_q <= ST_MUL_DEN;
          end
        end
        ST_MUL_DEN: begin
          if (mul_done) begin
            den_q <= mul_prod[33:0]; state_q <= ST_MUL_M981;
          end
        end
        ST_MUL_M981: begin
          if (mul_done) begin
            m981_q <= mul_prod[18:0]; state_q <= ST_MUL_RHS;
          end
        end
        ST_MUL_RHS: begin
          if (mul_done) begin
            active_q <= active_c;
            state_q  <= ST_OUT;
          end
        end
        ST_OUT: begin
          // hold until the output register is free
          if (!out_valid_q || out_ready_i) begin
            for (int i = 0; i < 4; i++) wing_q[i] <= wing_d[i];
            mode_q      <= mode_c;
            radius_q    <= r_neg ? -$signed({1'b0, rmag_q}) : $signed({1'b0, rmag_q});
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  logic [CW-1:0] o0, o1, o2, o3;
  assign o0 = CW'(wing_q[0]);
  assign o1 = CW'(wing_q[1]);
  assign o2 = CW'(wing_q[2]);
  assign o3 = CW'(wing_q[3]);

  assign in_ready_o          = (state_q == ST_IDLE);
  assign out_valid_o         = out_valid_q;
  assign angle_rear_high_o   = o0[7:0];
  assign angle_rear_low_o    = o1[7:0];
  assign angle_front_right_o = o2[7:0];
  assign angle_front_left_o  = o3[7:0];
  assign wing_mode_o         = mode_q;
  assign corner_radius_o     = radius_q;

  // the two arithmetic units never start together
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_start && mul_start))
    else $error("both units launched");

  // an accepted item takes the block out of idle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("still idle after accept");

  // a wide-corner result always carries a radius beyond the threshold
  a_wide_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && wing_mode_o == awac_pkg::MODE_WIDE) |->
      (corner_radius_o > 16'sd50 || corner_radius_o < -16'sd50))
    else $error("wide mode with narrow radius");

  // a division only completes in a division state
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV_S || state_q == ST_DIV_DEG || state_q == ST_DIV_RAD))
    else $error("division done outside division state");

endmodule

[rtl/awac_serial_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on awac_pkg for the operand width.
module awac_serial_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [awac_pkg::DIV_W-1:0]   dividend_i,
  input  logic [awac_pkg::DIV_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [awac_pkg::DIV_W-1:0]   quot_o
);
  localparam int unsigned DW = awac_pkg::DIV_W;
  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] quo_q, rem_q, dvs_q;
  logic [DW:0]   trial;
  logic [DW+1:0] sub;
  logic          ge;

  assign trial  = {rem_q, quo_q[DW-1]};
  assign sub    = {1'b0, trial} - {2'b00, dvs_q};
  assign ge     = ~sub[DW+1];
  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(DW);
      quo_q  <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
        rem_q <= ge ? sub[DW-1:0] : trial[DW-1:0];
        quo_q <= {quo_q[DW-2:0], ge};
      end
    end
  end

endmodule

[rtl/awac_serial_mul.sv]
// Shift-and-add multiplier, one multiplier bit per cycle, unsigned.
// Depends on awac_pkg for the operand widths.
module awac_serial_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [awac_pkg::MUL_AW-1:0]  a_i,
  input  logic [awac_pkg::MUL_BW-1:0]  b_i,
  output logic                         done_o,
  output logic [awac_pkg::MUL_AW-1:0]  prod_o
);
  localparam int unsigned AW = awac_pkg::MUL_AW;
  localparam int unsigned BW = awac_pkg::MUL_BW;

  logic          busy_q;
  logic [AW-1:0] a_q, acc_q;
  logic [BW-1:0] b_q;

  // finish as soon as no multiplier bits remain
  assign done_o = busy_q && (b_q == '0);
  assign prod_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      a_q    <= '0;
      b_q    <= '0;
      acc_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      a_q    <= a_i;
      b_q    <= b_i;
      acc_q  <= '0;
    end else if (busy_q) begin
      if (b_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        acc_q <= b_q[0] ? acc_q + a_q : acc_q;
        a_q   <= {a_q[AW-2:0], 1'b0};
        b_q   <= {1'b0, b_q[BW-1:1]};
      end
    end
  end

endmodule

[dv/tb_aero_wing_angle_controller_unit.sv]
// Testbench for the aero wing angle controller: random and directed sensor
// items against an in-bench model of steering, radius, downforce and trim.
// Depends on awac_pkg and aero_wing_angle_controller_unit.
`timescale 1ns / 100ps

module tb_aero_wing_angle_controller_unit;

  typedef struct packed {
    logic signed [15:0] pitch;
    logic [7:0]         brake;
    logic [7:0]         throttle;
    logic [7:0]         steer;
    logic [7:0]         grip;
    logic [7:0]         kg;
    logic signed [7:0]  roll;
    logic [7:0]         speed;
  } sensors_t;

  typedef struct packed {
    logic [7:0]         rh;
    logic [7:0]         rl;
    logic [7:0]         fr;
    logic [7:0]         fl;
    logic [2:0]         mode;
    logic signed [15:0] radius;
  } wings_t;

  localparam int unsigned LIMIT_CYCLES = 1_500_000;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam logic [4:0] ADDR_STEP = 5'd4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  sensors_t drv = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  wings_t mon;

  aero_wing_angle_controller_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .pitch_rate_i(drv.pitch), .brake_level_i(drv.brake),
    .throttle_level_i(drv.throttle), .steering_raw_i(drv.steer),
    .grip_raw_i(drv.grip), .driver_kg_i(drv.kg), .roll_deg_i(drv.roll),
    .speed_raw_i(drv.speed),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .angle_rear_high_o(mon.rh), .angle_rear_low_o(mon.rl),
    .angle_front_right_o(mon.fr), .angle_front_left_o(mon.fl),
    .wing_mode_o(mon.mode), .corner_radius_o(mon.radius)
  );

  always #4 clk_i = ~clk_i;

  // Model state: limits and wing angles, held as the block holds them
  logic [7:0] close_lim [4];
  logic [7:0] open_lim [4];
  logic [7:0] wing_pos [4];
  int sin_tab [91] = '{
    0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
    11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
    22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
    32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
    42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
    50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
    56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
    61584, 61966, 62328, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
    64540, 64729, 64898, 65048, 65177, 65287, 65376, 65446, 65496, 65526,
    65536};

  sensors_t pending_items[$];
  wings_t   expected_wings[$];
  int unsigned mismatches = 0;
  int unsigned cycle = 0;
  int unsigned send_idle_pct = 0, recv_idle_pct = 0;
  int unsigned hold_off = 0;

  function automatic int steer_ratio(input int a);
    if (a <= 7) return 400;
    if (a <= 19) return 399;
    if (a <= 30) return 398;
    if (a <= 38) return 396;
    if (a <= 45) return 395;
    if (a <= 57) return 392;
    if (a <= 68) return 387;
    if (a <= 76) return 384;
    if (a <= 87) return 377;
    if (a <= 95) return 371;
    if (a <= 103) return 364;
    if (a <= 109) return 353;
    return 338;
  endfunction

  // Work out the wing command for one item and advance the model state
  function automatic wings_t predict_wings(input sensors_t x);
    int s, a, r, deg, radius, roll, ar, sinr, cosr, mass, fric, d, w;
    longint num, den;
    bit hit;
    wings_t y;
    s = (int'(x.steer) * 141 - 18000) / 100;
    a = s < 0 ? -s : s;
    r = steer_ratio(a);
    deg = (200 * a + r) / (2 * r);
    if (deg > 90) deg = 90;
    if (deg == 0) radius = 32767;
    else begin
      radius = 105513 / sin_tab[deg];
      if (s < 0) radius = -radius;
    end
    roll = int'(x.roll);
    if (roll > 90) roll = 90;
    if (roll < -90) roll = -90;
    ar = roll < 0 ? -roll : roll;
    sinr = roll < 0 ? -sin_tab[ar] : sin_tab[ar];
    cosr = sin_tab[90 - ar];
    mass = 230 + int'(x.kg);
    num = longint'(mass) * x.speed * x.speed * cosr;
    fric = (int'(x.grip) * 131072 + 127) / 255;
    den = longint'(radius) * longint'(fric - sinr);
    if (den == 0) hit = num > 0;
    else if (den > 0) hit = num * 100 > longint'(mass) * 981 * den;
    else hit = 1'b0;
    if (hit) begin
      y.mode = awac_pkg::MODE_DOWNFORCE;
      wing_pos = close_lim;
    end else if (radius > 50 || radius < -50) begin
      y.mode = awac_pkg::MODE_WIDE;
      wing_pos = open_lim;
    end else if (x.brake > awac_pkg::PEDAL_TRIP) begin
      y.mode = awac_pkg::MODE_BRAKE;
      wing_pos = close_lim;
    end else if (x.throttle > awac_pkg::PEDAL_TRIP) begin
      y.mode = awac_pkg::MODE_THROTTLE;
      wing_pos = open_lim;
    end else begin
      y.mode = awac_pkg::MODE_TRIM;
      for (int i = 0; i < 4; i++) begin
        d = x.pitch > 0 ? 1 : (x.pitch < 0 ? -1 : 0);
        if (i >= 2) d = -d;
        w = int'(wing_pos[i]) + d;
        if (w > int'(close_lim[i])) w = close_lim[i];
        if (w < int'(open_lim[i])) w = open_lim[i];
        wing_pos[i] = w[7:0];
      end
    end
    y.rh = wing_pos[0];
    y.rl = wing_pos[1];
    y.fr = wing_pos[2];
    y.fl = wing_pos[3];
    y.radius = radius[15:0];
    return y;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycle, what, got, want);
    mismatches++;
  endtask

  // Driver: present the next queued item, hold it until accepted
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (in_valid_i) expected_wings.push_back(predict_wings(drv));
        if (pending_items.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          drv <= pending_items.pop_front();
          in_valid_i <= 1'b1;
        end else in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_wings.size() == 0) begin
          $display("unexpected result at cycle %0d", cycle);
          mismatches++;
        end else begin
          wings_t e;
          e = expected_wings.pop_front();
          if (mon.rh !== e.rh) report_mismatch("rear high", mon.rh, e.rh);
          if (mon.rl !== e.rl) report_mismatch("rear low", mon.rl, e.rl);
          if (mon.fr !== e.fr) report_mismatch("front right", mon.fr, e.fr);
          if (mon.fl !== e.fl) report_mismatch("front left", mon.fl, e.fl);
          if (mon.mode !== e.mode) report_mismatch("mode", mon.mode, e.mode);
          if (mon.radius !== e.radius) report_mismatch("radius", mon.radius, e.radius);
        end
      end
      if (hold_off != 0) begin
        hold_off <= hold_off - 1;
        out_ready_i <= 1'b0;
      end else out_ready_i <= $urandom_range(99, 0) >= recv_idle_pct;
    end
  end

  // Timeout watchdog
  always @(posedge clk_i) begin
    if (cycle >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic apb_write(input int idx, input logic [7:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_STEP * idx[4:0]; pwdata <= {24'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx[0]) open_lim[idx >> 1] = val;
    else close_lim[idx >> 1] = val;
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || expected_wings.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Well-formed sensor sets mostly; bias steering near centre, and far off it so trim runs
  function automatic sensors_t random_item();
    sensors_t x;
    x = sensors_t'(72'({$urandom, $urandom, $urandom}));
    case ($urandom_range(3, 0))
      0: x.steer = 8'($urandom_range(140, 115));
      1: x.steer = 8'($urandom_range(255, 160));
      default: ;
    endcase
    if ($urandom_range(3, 0) != 0) x.roll = 8'(int'($urandom_range(180, 0)) - 90);
    if ($urandom_range(1, 0)) x.speed = 8'($urandom_range(40, 0));
    if ($urandom_range(1, 0)) begin
      x.brake = 8'($urandom_range(178, 0));
      x.throttle = 8'($urandom_range(178, 0));
    end
    return x;
  endfunction

  initial begin
    sensors_t x;
    for (int i = 0; i < 4; i++) begin
      close_lim[i] = i < 2 ? 8'd100 : 8'd50;
      open_lim[i] = 8'd0;
      wing_pos[i] = 8'd0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < 8; i++) apb_write(i, 8'($urandom_range(i[0] ? 60 : 255, i[0] ? 0 : 60)));

    // Directed: field extremes, pedal trip levels, straight, roll saturation, den zero
    send_idle_pct = 29; recv_idle_pct = 65;
    for (int k = 0; k < 24; k++) begin
      x = '0;
      x.steer = 8'd128; x.speed = 8'd0; x.roll = 8'sd0;
      case (k)
        0: x = '1;
        1: x = '0;
        2: begin x.steer = 8'd255; x.speed = 8'd255; x.kg = 8'd255; end
        3: x.steer = 8'd0;
        4: x.brake = 8'd179;
        5: x.brake = 8'd178;
        6: x.throttle = 8'd179;
        7: x.throttle = 8'd255;
        8: x.pitch = 16'sh7fff;
        9: x.pitch = -16'sh8000;
        10: x.pitch = 16'sd0;
        11: begin x.roll = 8'sh7f; x.speed = 8'd100; end
        12: begin x.roll = -8'sh80; x.speed = 8'd100; end
        13: begin x.roll = 8'sd90; x.grip = 8'd255; end
        14: begin x.steer = 8'd128; x.speed = 8'd200; x.grip = 8'd0; end
        15: begin x.steer = 8'd100; x.grip = 8'd0; x.speed = 8'd10; end
        16: begin x.steer = 8'd200; x.grip = 8'd255; x.speed = 8'd255; end
        17: begin x.steer = 8'd60; x.pitch = 16'sd1; end
        18: begin x.steer = 8'd200; x.pitch = -16'sd1; end
        19: begin x.grip = 8'd255; x.speed = 8'd255; x.steer = 8'd1; end
        20: x.steer = 8'd127;
        21: x.steer = 8'd129;
        22: begin x.roll = -8'sd90; x.speed = 8'd50; end
        default: x = sensors_t'(72'({$urandom, $urandom, $urandom}));
      endcase
      pending_items.push_back(x);
    end
    for (int k = 0; k < 200; k++) pending_items.push_back(random_item());
    // Long receiver stall while the sender keeps offering
    while (expected_wings.size() == 0) @(posedge clk_i);
    hold_off = 3000;
    wait_drained();

    apb_write(0, 8'd255); apb_write(1, 8'd0); apb_write(2, 8'd0); apb_write(3, 8'd255);
    apb_write(4, 8'd10); apb_write(5, 8'd20); apb_write(6, 8'd255); apb_write(7, 8'd255);
    send_idle_pct = 65; recv_idle_pct = 29;
    for (int k = 0; k < 250; k++) pending_items.push_back(random_item());
    wait_drained();

    for (int i = 0; i < 8; i++) apb_write(i, 8'($urandom));
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int k = 0; k < 280; k++) pending_items.push_back(random_item());
    wait_drained();

    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

[files.f]
rtl/awac_pkg.sv
rtl/awac_serial_div.sv
rtl/awac_serial_mul.sv
rtl/aero_wing_angle_controller_unit.sv
dv/tb_aero_wing_angle_controller_unit.sv
